/* hw/rtl/swrl_pkg.sv */
package swrl_pkg;

    // Log geometry
    localparam int LOG_DEPTH = 64;
    localparam int STAMP_W   = 32;
    localparam int WIN_W     = 17;
    localparam int MAXREQ_W  = 5;
    localparam int ACT_W     = 2;
    localparam int LIVE_W    = 7;
    localparam int LIVE_MAX  = 127;

    // Occupancy count width, never narrower than the reported field
    localparam int CNT_W = ($clog2(LOG_DEPTH + 1) > LIVE_W) ? $clog2(LOG_DEPTH + 1) : LIVE_W;

    // Popcount tree: groups of eight valid bits
    localparam int GRP     = 8;
    localparam int NGRP    = (LOG_DEPTH + GRP - 1) / GRP;
    localparam int GCNT_W  = $clog2(GRP + 1);

    // Register port
    localparam int ADDR_W = 3;
    localparam int DATA_W = 32;

    localparam logic [MAXREQ_W-1:0] MAXREQ_RST = MAXREQ_W'(5);
    localparam logic [WIN_W-1:0]    WIN_RST    = WIN_W'(60);

    // Register indexes (paddr[2])
    localparam logic REG_MAX_REQ = 1'b0;
    localparam logic REG_WINDOW  = 1'b1;

    // Action codes
    localparam logic [ACT_W-1:0] ACT_ADD   = 2'd0;
    localparam logic [ACT_W-1:0] ACT_CHECK = 2'd1;
    localparam logic [ACT_W-1:0] ACT_CLEAR = 2'd2;

    typedef struct packed {
        logic [ACT_W-1:0]   action;
        logic [STAMP_W-1:0] now_seconds;
    } t_in_item;

    typedef struct packed {
        logic              limit_reached;
        logic [LIVE_W-1:0] live_count;
        logic              add_dropped;
    } t_out_item;

    // Per-cycle command broadcast to the row of cells
    typedef struct packed {
        logic clear;
        logic shift;
        logic prune;
        logic compact;
    } t_cell_ctrl;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SETTLE,
        ST_RESULT
    } t_state;

endpackage

/* hw/rtl/swrl_cell.sv */
module swrl_cell (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  swrl_pkg::t_cell_ctrl          i_ctrl,
    input  logic [swrl_pkg::STAMP_W-1:0]  i_now,
    input  logic [swrl_pkg::WIN_W-1:0]    i_window,
    input  logic                          i_pair_left,
    input  logic                          i_pair_right,
    input  logic [swrl_pkg::STAMP_W-1:0]  i_left_stamp,
    input  logic                          i_left_valid,
    input  logic [swrl_pkg::STAMP_W-1:0]  i_right_stamp,
    input  logic                          i_right_valid,
    output logic [swrl_pkg::STAMP_W-1:0]  o_stamp,
    output logic                          o_valid
);

    logic [swrl_pkg::STAMP_W-1:0] r_stamp;
    logic [swrl_pkg::STAMP_W-1:0] n_stamp;
    logic                         r_valid;
    logic                         n_valid;
    logic [swrl_pkg::STAMP_W-1:0] w_age;
    logic                         w_stale;

    // Age test: too old, or stamped in the future after the time stepped back
    assign w_age   = i_now - r_stamp;
    assign w_stale = (r_stamp > i_now) ||
                     ((i_now > r_stamp) &&
                      (w_age > {{(swrl_pkg::STAMP_W - swrl_pkg::WIN_W){1'b0}}, i_window}));

    // Cell update: clear, shift-in from the left, prune, or odd-even compaction step
    always_comb begin
        n_stamp = r_stamp;
        n_valid = r_valid;
        if (i_ctrl.clear) begin
            n_valid = 1'b0;
        end else if (i_ctrl.shift) begin
            n_stamp = i_left_stamp;
            n_valid = i_left_valid;
        end else if (i_ctrl.prune) begin
            n_valid = r_valid && !w_stale;
        end else if (i_ctrl.compact) begin
            if (i_pair_left && !r_valid && i_right_valid) begin
                n_stamp = i_right_stamp;
                n_valid = 1'b1;
            end else if (i_pair_right && !i_left_valid && r_valid) begin
                n_valid = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_stamp <= n_stamp;
    end

    assign o_stamp = r_stamp;
    assign o_valid = r_valid;

endmodule

/* hw/rtl/swrl_popcnt.sv */
module swrl_popcnt (
    input  logic                           i_clk,
    input  logic [swrl_pkg::LOG_DEPTH-1:0] i_valid,
    output logic [swrl_pkg::CNT_W-1:0]     o_total
);

    logic [swrl_pkg::NGRP*swrl_pkg::GRP-1:0] w_pad;
    logic [swrl_pkg::GCNT_W-1:0]             r_grp [swrl_pkg::NGRP];
    logic [swrl_pkg::GCNT_W-1:0]             n_grp [swrl_pkg::NGRP];
    logic [swrl_pkg::CNT_W-1:0]              r_total;
    logic [swrl_pkg::CNT_W-1:0]              n_total;

    assign w_pad = (swrl_pkg::NGRP * swrl_pkg::GRP)'(i_valid);

    // Stage 1: count each group of eight
    always_comb begin
        for (int g = 0; g < swrl_pkg::NGRP; g++) begin
            n_grp[g] = '0;
            for (int b = 0; b < swrl_pkg::GRP; b++) begin
                n_grp[g] = n_grp[g] + swrl_pkg::GCNT_W'(w_pad[g*swrl_pkg::GRP + b]);
            end
        end
    end

    // Stage 2: add the group counts
    always_comb begin
        n_total = '0;
        for (int g = 0; g < swrl_pkg::NGRP; g++) begin
            n_total = n_total + swrl_pkg::CNT_W'(r_grp[g]);
        end
    end

    always_ff @(posedge i_clk) begin
        r_grp   <= n_grp;
        r_total <= n_total;
    end

    assign o_total = r_total;

endmodule

/* hw/rtl/sliding_window_request_limiter_top.sv */
// For check, clear and idle actions the item passes through the EXEC, SETTLE and RESULT
// states, and the result is registered into the output from RESULT.
// An add waits in EXEC until the odd-even compaction of the cell row has closed all holes.
// One item at a time: a new item is taken only in the idle state, after the last one has
// gone through accept, exec, two popcount stages and result; a stalled output holds it in
// the result state.
// Reset (synchronous, active low) clears every valid bit and the output valid, and sets
// max_requests to 5 and window_seconds to 60; no clearing pass is needed.
module sliding_window_request_limiter_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // item input
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  swrl_pkg::t_in_item                  i_in_item,
    // result output
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output swrl_pkg::t_out_item                 o_out_item,
    // register port
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [swrl_pkg::ADDR_W-1:0]         paddr,
    input  logic [swrl_pkg::DATA_W-1:0]         pwdata,
    output logic [swrl_pkg::DATA_W-1:0]         prdata,
    output logic                                pready
);

    localparam int D = swrl_pkg::LOG_DEPTH;

    swrl_pkg::t_state                 r_state;
    swrl_pkg::t_state                 n_state;
    logic                             r_settle;
    logic                             r_phase;
    logic [swrl_pkg::ACT_W-1:0]       r_action;
    logic [swrl_pkg::STAMP_W-1:0]     r_now;
    logic                             r_dropped;
    logic [swrl_pkg::MAXREQ_W-1:0]    r_max_req;
    logic [swrl_pkg::WIN_W-1:0]       r_window;
    logic                             r_out_valid;
    swrl_pkg::t_out_item              r_out_item;
    swrl_pkg::t_out_item              n_out_item;

    swrl_pkg::t_cell_ctrl             w_ctrl;
    logic                             w_accept;
    logic                             w_load_out;
    logic                             w_set_drop;
    logic                             w_packed;
    logic                             w_full;
    logic [D-2:0]                     w_gap;
    logic [D-1:0]                     w_valid;
    logic [swrl_pkg::STAMP_W-1:0]     w_stamp [D];
    logic [swrl_pkg::CNT_W-1:0]       w_total;
    logic                             w_cfg_wr;

    // Register port
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_req <= swrl_pkg::MAXREQ_RST;
            r_window  <= swrl_pkg::WIN_RST;
        end else if (w_cfg_wr) begin
            case (paddr[2])
                swrl_pkg::REG_MAX_REQ: r_max_req <= pwdata[swrl_pkg::MAXREQ_W-1:0];
                swrl_pkg::REG_WINDOW:  r_window  <= pwdata[swrl_pkg::WIN_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            swrl_pkg::REG_MAX_REQ: prdata = swrl_pkg::DATA_W'(r_max_req);
            swrl_pkg::REG_WINDOW:  prdata = swrl_pkg::DATA_W'(r_window);
            default:               prdata = '0;
        endcase
    end

    // Row state: packed means no empty cell sits below a valid one
    assign w_gap    = ~w_valid[D-2:0] & w_valid[D-1:1];
    assign w_packed = ~|w_gap;
    assign w_full   = w_packed && w_valid[D-1];

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            swrl_pkg::ST_IDLE: begin
                if (i_in_valid) n_state = swrl_pkg::ST_EXEC;
            end
            swrl_pkg::ST_EXEC: begin
                if (!(r_action == swrl_pkg::ACT_ADD && !w_packed)) begin
                    n_state = swrl_pkg::ST_SETTLE;
                end
            end
            swrl_pkg::ST_SETTLE: begin
                if (r_settle) n_state = swrl_pkg::ST_RESULT;
            end
            swrl_pkg::ST_RESULT: begin
                if (!r_out_valid || !i_out_stall) n_state = swrl_pkg::ST_IDLE;
            end
            default: n_state = swrl_pkg::ST_IDLE;
        endcase
    end

    // Control outputs
    always_comb begin
        w_ctrl     = '0;
        w_set_drop = 1'b0;
        w_load_out = 1'b0;
        o_in_stall = 1'b1;
        case (r_state)
            swrl_pkg::ST_IDLE: begin
                o_in_stall = 1'b0;
            end
            swrl_pkg::ST_EXEC: begin
                w_ctrl.shift = (r_action == swrl_pkg::ACT_ADD) && w_packed && !w_full;
                w_set_drop   = (r_action == swrl_pkg::ACT_ADD) && w_full;
                w_ctrl.prune = (r_action == swrl_pkg::ACT_CHECK);
                w_ctrl.clear = (r_action == swrl_pkg::ACT_CLEAR);
            end
            swrl_pkg::ST_RESULT: begin
                w_load_out = !r_out_valid || !i_out_stall;
            end
            default: ;
        endcase
        w_ctrl.compact = !(w_ctrl.shift || w_ctrl.prune || w_ctrl.clear);
    end

    assign w_accept = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= swrl_pkg::ST_IDLE;
            r_settle    <= 1'b0;
            r_phase     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_settle <= (r_state == swrl_pkg::ST_SETTLE) && !r_settle;
            r_phase  <= !r_phase;
            if (w_load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Item and result payload
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_action  <= i_in_item.action;
            r_now     <= i_in_item.now_seconds;
            r_dropped <= 1'b0;
        end else if (w_set_drop) begin
            r_dropped <= 1'b1;
        end
        if (w_load_out) begin
            r_out_item <= n_out_item;
        end
    end

    always_comb begin
        n_out_item.limit_reached = (r_action == swrl_pkg::ACT_CHECK) &&
                                   (w_total > swrl_pkg::CNT_W'({r_max_req, 1'b0}));
        n_out_item.live_count    = (w_total > swrl_pkg::CNT_W'(swrl_pkg::LIVE_MAX)) ?
                                   swrl_pkg::LIVE_W'(swrl_pkg::LIVE_MAX) :
                                   w_total[swrl_pkg::LIVE_W-1:0];
        n_out_item.add_dropped   = r_dropped;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    // Row of cells; new stamps enter at cell 0, compaction pulls entries toward cell 0
    for (genvar i = 0; i < D; i++) begin : g_cell
        logic [swrl_pkg::STAMP_W-1:0] w_lstamp;
        logic                         w_lvalid;
        logic [swrl_pkg::STAMP_W-1:0] w_rstamp;
        logic                         w_rvalid;
        logic                         w_pl;
        logic                         w_pr;

        if (i == 0) begin : g_head
            assign w_lstamp = r_now;
            assign w_lvalid = 1'b1;
            assign w_pr     = 1'b0;
        end else begin : g_body
            assign w_lstamp = w_stamp[i-1];
            assign w_lvalid = w_valid[i-1];
            assign w_pr     = (1'((i - 1) % 2) == r_phase);
        end

        if (i == D - 1) begin : g_tail
            assign w_rstamp = '0;
            assign w_rvalid = 1'b0;
            assign w_pl     = 1'b0;
        end else begin : g_inner
            assign w_rstamp = w_stamp[i+1];
            assign w_rvalid = w_valid[i+1];
            assign w_pl     = (1'(i % 2) == r_phase);
        end

        swrl_cell u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_ctrl        (w_ctrl),
            .i_now         (r_now),
            .i_window      (r_window),
            .i_pair_left   (w_pl),
            .i_pair_right  (w_pr),
            .i_left_stamp  (w_lstamp),
            .i_left_valid  (w_lvalid),
            .i_right_stamp (w_rstamp),
            .i_right_valid (w_rvalid),
            .o_stamp       (w_stamp[i]),
            .o_valid       (w_valid[i])
        );
    end

    // Occupancy count, two register stages behind the valid bits
    swrl_popcnt u_popcnt (
        .i_clk   (i_clk),
        .i_valid (w_valid),
        .o_total (w_total)
    );

    // A shift-in never pushes a live entry off the end of the row
    a_shift_no_loss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctrl.shift |-> !w_valid[D-1])
        else $error("shift-in would lose the last entry");

    // Clear empties the whole row, seen in the cycle after the clear
    a_clear_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctrl.clear |=> (w_valid == '0))
        else $error("valid bits left after clear");

    // Compaction moves entries but never creates or drops one
    a_compact_keeps_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == swrl_pkg::ST_SETTLE && r_settle) |->
        ($countones(w_valid) == $past($countones(w_valid))))
        else $error("entry count changed during compaction");

    // The popcount pipeline has caught up by the time the result is formed
    a_count_settled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == swrl_pkg::ST_RESULT) |-> (int'(w_total) == $countones(w_valid)))
        else $error("occupancy count not settled at result");

endmodule

/* bench/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;

    localparam logic [swrl_pkg::ACT_W-1:0] ACT_IDLE = 2'd3;   // unused action code, no effect
    localparam int ITEMS_TOTAL = 550;
    localparam int PHASE_ITEMS = 60;
    localparam int LONG_HOLD   = 300;
    localparam int STALL_LIMIT = 5000;

    typedef struct {
        swrl_pkg::t_in_item item;
        bit                 wait_drain;
    } t_pending;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    // item channels
    logic                 in_valid = 1'b0;
    swrl_pkg::t_in_item   in_item = '0;
    logic                 o_in_stall;
    logic                 o_out_valid;
    logic                 out_stall = 1'b0;
    swrl_pkg::t_out_item  o_out_item;

    // register port
    logic                          psel = 1'b0;
    logic                          penable = 1'b0;
    logic                          pwrite = 1'b0;
    logic [swrl_pkg::ADDR_W-1:0]   paddr = '0;
    logic [swrl_pkg::DATA_W-1:0]   pwdata = '0;
    logic [swrl_pkg::DATA_W-1:0]   prdata;
    logic                          pready;

    // predictor state: timestamp log and live register copies
    logic [swrl_pkg::STAMP_W-1:0]  log_stamp [swrl_pkg::LOG_DEPTH];
    bit                            log_live [swrl_pkg::LOG_DEPTH];
    int                            log_count = 0;
    logic [swrl_pkg::MAXREQ_W-1:0] cfg_max_req = swrl_pkg::MAXREQ_RST;
    logic [swrl_pkg::WIN_W-1:0]    cfg_window = swrl_pkg::WIN_RST;

    t_pending            request_q [$];
    swrl_pkg::t_out_item verdict_q [$];

    bit                           no_idle = 1'b0;
    bit                           drain_next = 1'b0;
    logic                         hold_start = 1'b0;
    logic [swrl_pkg::STAMP_W-1:0] wall_time = '0;
    int n_queued = 0;
    int n_sent = 0;
    int n_verdicts = 0;
    int n_limit_hits = 0;
    int n_drops = 0;
    int n_errors = 0;
    int ph_idx = 0;
    int gap_left = 0;
    int stall_left = 0;
    int hold_left = 0;
    int dead_cycles = 0;

    sliding_window_request_limiter_top u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (o_out_item),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // Mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Verdict for one request; updates the predictor's log
    function automatic swrl_pkg::t_out_item predict_verdict(swrl_pkg::t_in_item req);
        swrl_pkg::t_out_item v;
        bit placed;
        bit stale;
        v = '0;
        placed = 1'b0;
        case (req.action)
            swrl_pkg::ACT_ADD: begin
                for (int i = 0; i < swrl_pkg::LOG_DEPTH; i++) begin
                    if (!placed && !log_live[i]) begin
                        log_stamp[i] = req.now_seconds;
                        log_live[i] = 1'b1;
                        log_count++;
                        placed = 1'b1;
                    end
                end
                v.add_dropped = !placed;
            end
            swrl_pkg::ACT_CHECK: begin
                for (int i = 0; i < swrl_pkg::LOG_DEPTH; i++) begin
                    if (log_live[i]) begin
                        // too old, or ahead of now after the clock stepped back
                        stale = (req.now_seconds > log_stamp[i] &&
                                 req.now_seconds - log_stamp[i] >
                                 swrl_pkg::STAMP_W'(cfg_window)) ||
                                (log_stamp[i] > req.now_seconds);
                        if (stale) begin
                            log_live[i] = 1'b0;
                            log_count--;
                        end
                    end
                end
                v.limit_reached = log_count > 2 * int'(cfg_max_req);
            end
            swrl_pkg::ACT_CLEAR: begin
                for (int i = 0; i < swrl_pkg::LOG_DEPTH; i++) log_live[i] = 1'b0;
                log_count = 0;
            end
            default: ;
        endcase
        v.live_count = swrl_pkg::LIVE_W'((log_count > swrl_pkg::LIVE_MAX) ?
                                         swrl_pkg::LIVE_MAX : log_count);
        return v;
    endfunction

    task automatic check_field(input string name, input logic [7:0] exp_v,
                               input logic [7:0] got_v);
        if (exp_v !== got_v) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_v, got_v);
            n_errors++;
        end
    endtask

    // One register transfer; a read compares prdata with data
    task automatic apb_xfer(input bit wr, input logic idx,
                            input logic [swrl_pkg::DATA_W-1:0] data);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= wr;
        paddr <= {idx, 2'b00};
        pwdata <= wr ? data : '0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        while (!pready) @(negedge i_clk);
        if (!wr && prdata !== data) begin
            $display("%0t: register %0d readback, expected %0h, got %0h",
                     $time, idx, data, prdata);
            n_errors++;
        end
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic set_limits(input logic [swrl_pkg::MAXREQ_W-1:0] mr,
                              input logic [swrl_pkg::WIN_W-1:0] win);
        logic [swrl_pkg::DATA_W-1:0] wd;
        // junk in the unused upper bits must be dropped
        wd = $urandom;
        wd[swrl_pkg::MAXREQ_W-1:0] = mr;
        apb_xfer(1'b1, swrl_pkg::REG_MAX_REQ, wd);
        wd = $urandom;
        wd[swrl_pkg::WIN_W-1:0] = win;
        apb_xfer(1'b1, swrl_pkg::REG_WINDOW, wd);
        cfg_max_req = mr;
        cfg_window = win;
        apb_xfer(1'b0, swrl_pkg::REG_MAX_REQ, swrl_pkg::DATA_W'(mr));
        apb_xfer(1'b0, swrl_pkg::REG_WINDOW, swrl_pkg::DATA_W'(win));
    endtask

    task automatic queue_item(input logic [swrl_pkg::ACT_W-1:0] act,
                              input logic [swrl_pkg::STAMP_W-1:0] t);
        t_pending p;
        p.item.action = act;
        p.item.now_seconds = t;
        p.wait_drain = drain_next;
        drain_next = 1'b0;
        request_q.push_back(p);
        n_queued++;
    endtask

    task automatic wait_idle();
        while (request_q.size() != 0 || in_valid || verdict_q.size() != 0) @(posedge i_clk);
    endtask

    // An occasional clear, then adds and checks around the window edges, with the clock sometimes stepping back
    task automatic window_traffic();
        int len;
        int r;
        logic [swrl_pkg::STAMP_W-1:0] t;
        len = $urandom_range(4, 20);
        if ($urandom_range(0, 2) == 0) queue_item(swrl_pkg::ACT_CLEAR, $urandom);
        repeat (len) begin
            r = $urandom_range(0, 99);
            if (r < 60) begin
                if ($urandom_range(0, 3) == 0) wall_time += $urandom_range(1, 3);
                queue_item(swrl_pkg::ACT_ADD, wall_time);
            end else if (r < 90) begin
                case ($urandom_range(0, 4))
                    0: t = wall_time;
                    1: t = wall_time + swrl_pkg::STAMP_W'(cfg_window);
                    2: t = wall_time + swrl_pkg::STAMP_W'(cfg_window) + 1;
                    3: t = wall_time - $urandom_range(1, 3);
                    default: t = wall_time + $urandom_range(0, 10);
                endcase
                queue_item(swrl_pkg::ACT_CHECK, t);
                if ($urandom_range(0, 1)) wall_time = t;
            end else begin
                wall_time += $urandom_range(0, 2 * int'(cfg_window) + 2);
            end
        end
    endtask

    // Fill the log near or past capacity, so adds may get dropped and the limit may trip
    task automatic fill_log();
        int n;
        queue_item(swrl_pkg::ACT_CLEAR, wall_time);
        n = $urandom_range(60, 70);
        for (int k = 0; k < n; k++) begin
            if ($urandom_range(0, 4) == 0) wall_time++;
            queue_item(swrl_pkg::ACT_ADD, wall_time);
            if (k % 16 == 15) queue_item(swrl_pkg::ACT_CHECK, wall_time);
        end
        queue_item(swrl_pkg::ACT_CHECK, wall_time);
    endtask

    task automatic noise_items();
        repeat ($urandom_range(3, 8)) begin
            queue_item(swrl_pkg::ACT_W'($urandom_range(0, 3)), $urandom);
        end
    endtask

    // Driver: offers queued requests with random gaps
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && !o_in_stall) begin
                verdict_q.push_back(predict_verdict(in_item));
                n_sent++;
            end
            if (!in_valid || !o_in_stall) begin
                if (gap_left > 0) begin
                    gap_left--;
                    in_valid <= 1'b0;
                end else if (request_q.size() != 0 &&
                             (!request_q[0].wait_drain ||
                              (verdict_q.size() == 0 && !in_valid))) begin
                    in_item <= request_q[0].item;
                    in_valid <= 1'b1;
                    request_q.pop_front();
                    gap_left = pick_gap();
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: random stalls, one long hold on request, checks each verdict
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !out_stall) begin
                n_verdicts++;
                if (verdict_q.size() == 0) begin
                    $display("%0t: unexpected item, expected none, got %p", $time, o_out_item);
                    n_errors++;
                end else begin
                    check_field("limit_reached", 8'(verdict_q[0].limit_reached),
                                8'(o_out_item.limit_reached));
                    check_field("live_count", 8'(verdict_q[0].live_count),
                                8'(o_out_item.live_count));
                    check_field("add_dropped", 8'(verdict_q[0].add_dropped),
                                8'(o_out_item.add_dropped));
                    if (verdict_q[0].limit_reached) n_limit_hits++;
                    if (verdict_q[0].add_dropped) n_drops++;
                    verdict_q.pop_front();
                end
            end
            if (hold_start) hold_left = LONG_HOLD;
            if (hold_left > 0) begin
                hold_left--;
                out_stall <= 1'b1;
            end else if (stall_left > 0) begin
                stall_left--;
                out_stall <= 1'b1;
            end else begin
                out_stall <= 1'b0;
                if ($urandom_range(0, 99) < 30) stall_left = pick_gap();
            end
        end
    end

    // Watchdog: too long without any handshake
    always @(posedge i_clk) begin
        if (!i_rst_n || (in_valid && !o_in_stall) || (o_out_valid && !out_stall) ||
            (psel && penable)) begin
            dead_cycles = 0;
        end else begin
            dead_cycles++;
            if (dead_cycles >= STALL_LIMIT) begin
                $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
                $display("tb_top failed");
                $finish;
            end
        end
    end

    initial begin
        int start;
        int r;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: empty check, time extremes, future entry, window edge, idle code, clear
        queue_item(swrl_pkg::ACT_CHECK, 32'h0000_0000);
        queue_item(swrl_pkg::ACT_ADD, 32'h0000_0000);
        queue_item(swrl_pkg::ACT_ADD, 32'hFFFF_FFFF);
        queue_item(swrl_pkg::ACT_CHECK, 32'hFFFF_FFFF);
        queue_item(swrl_pkg::ACT_CHECK, 32'hFFFF_FFFE);
        queue_item(ACT_IDLE, 32'h5A5A_A5A5);
        for (int k = 0; k <= 10; k++) queue_item(swrl_pkg::ACT_ADD, 32'(1000 + k));
        queue_item(swrl_pkg::ACT_CHECK, 32'd1010);
        queue_item(swrl_pkg::ACT_CHECK, 32'd1061);
        queue_item(ACT_IDLE, 32'hFFFF_FFFF);
        queue_item(swrl_pkg::ACT_CLEAR, 32'h0000_0000);
        queue_item(swrl_pkg::ACT_ADD, 32'hFFFF_FFFF);

        // Random phases, each under its own limit setting
        while (n_queued < ITEMS_TOTAL) begin
            wait_idle();
            case (ph_idx % 8)
                0: set_limits(5'd0, 17'd0);
                1: set_limits(5'd31, 17'd131071);
                2: set_limits(swrl_pkg::MAXREQ_W'($urandom_range(0, 31)),
                              swrl_pkg::WIN_W'($urandom_range(0, 200)));
                3: set_limits(5'd31, 17'd0);
                4: set_limits(5'd0, 17'd131071);
                5: set_limits(5'd7, 17'd86400);
                6: set_limits(swrl_pkg::MAXREQ_W'($urandom_range(0, 31)),
                              swrl_pkg::WIN_W'($urandom_range(0, 131071)));
                default: set_limits(swrl_pkg::MAXREQ_W'($urandom_range(1, 31)),
                                    swrl_pkg::WIN_W'($urandom_range(1, 20)));
            endcase
            no_idle = (ph_idx % 4 == 2);
            start = n_queued;
            while (n_queued - start < PHASE_ITEMS && n_queued < ITEMS_TOTAL) begin
                r = $urandom_range(0, 99);
                if (r < 30) wall_time = (r < 5) ? 32'hFFFF_FFF0 + $urandom_range(0, 15) : $urandom;
                r = $urandom_range(0, 99);
                if (r < 5) drain_next = 1'b1;
                if (r < 65) window_traffic();
                else if (r < 80) fill_log();
                else noise_items();
            end
            // long receiver hold while the sender keeps offering
            if (ph_idx == 1) begin
                @(posedge i_clk);
                hold_start <= 1'b1;
                @(posedge i_clk);
                hold_start <= 1'b0;
            end
            ph_idx++;
        end

        wait_idle();
        repeat (swrl_pkg::LOG_DEPTH + 10) @(posedge i_clk);
        $display("Run: %0d requests under %0d limit settings, %0d verdicts checked.",
                 n_sent, ph_idx + 1, n_verdicts);
        $display("Seen: %0d limit hits, %0d dropped adds, %0d errors.",
                 n_limit_hits, n_drops, n_errors);
        if (n_errors == 0) begin
            $display("tb_top passed");
        end else begin
            $display("tb_top failed");
        end
        $finish;
    end

endmodule
